// ===== sv/window_variance_lumpiness_assert.svh =====
// ----------------------------------------------------------------------------
// window_variance_lumpiness_assert.svh
// Assertion macros shared by the lumpiness block.
// ----------------------------------------------------------------------------
`ifndef WINDOW_VARIANCE_LUMPINESS_ASSERT_SVH
`define WINDOW_VARIANCE_LUMPINESS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WVL_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wvl: assertion failed");

// next-cycle implication, disabled in reset
`define WVL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wvl: assertion failed");

`endif

// ===== sv/wvl_pkg.sv =====
// ----------------------------------------------------------------------------
// wvl_pkg
// Shared widths, defaults and width helpers for the lumpiness block.
// ----------------------------------------------------------------------------
package wvl_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int CFG_W     = 7;
    localparam int LUMP_W    = 40;
    localparam int MUL_W     = 32;
    localparam int NUM_W     = 128;

    localparam int DEF_MAX_WINDOWS       = 1024;
    localparam int DEF_MAX_WINDOW_LENGTH = 64;
    localparam int DEF_FRACTION_BITS     = 8;
    localparam int QUEUE_DEPTH           = 4;
    localparam int MIN_WINDOWS           = 2;

    localparam logic [CFG_W-1:0] RESET_WINDOW_LENGTH = 7'd10;

    function automatic int pos_width(input int max_len);
        return $clog2(max_len + 1);
    endfunction

    function automatic int sum_width(input int max_len);
        return $clog2(max_len * (1 << (SAMPLE_W - 1))) + 1;
    endfunction

    function automatic int sq_width(input int max_len);
        return $clog2(max_len * (1 << (2 * SAMPLE_W - 2)) + 1);
    endfunction

    function automatic int u_width(input int max_len);
        return $clog2(max_len * max_len * (1 << (2 * SAMPLE_W - 2)) + 1) + 1;
    endfunction

    function automatic int entry_width(input int max_len);
        return 2 + pos_width(max_len) + sum_width(max_len) + sq_width(max_len);
    endfunction

endpackage

// ===== sv/wvl_if.sv =====
// ----------------------------------------------------------------------------
// wvl_if
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
interface wvl_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [wvl_pkg::SAMPLE_W-1:0] sample;
    logic                                last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

interface wvl_result_if;
    logic                         valid;
    logic                         ready;
    logic [wvl_pkg::LUMP_W-1:0]   lumpiness;
    logic                         not_available;
    logic                         window_overflow;

    modport source (output valid, lumpiness, not_available, window_overflow, input ready);
    modport sink   (input valid, lumpiness, not_available, window_overflow, output ready);
endinterface

// ===== sv/wvl_queue.sv =====
// ----------------------------------------------------------------------------
// wvl_queue
// Short FIFO between the sample front end and the window back end.
// ----------------------------------------------------------------------------
module wvl_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/wvl_front.sv =====
// ----------------------------------------------------------------------------
// wvl_front
// Accepts samples, keeps the running window sums and queues each closed
// window and each end of series.
// ----------------------------------------------------------------------------
module wvl_front #(
    parameter int MAX_WINDOW_LENGTH = wvl_pkg::DEF_MAX_WINDOW_LENGTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [wvl_pkg::CFG_W-1:0]             cfg_data,
    wvl_sample_if.sink                            samples,
    output logic                                  push,
    output logic [wvl_pkg::entry_width(MAX_WINDOW_LENGTH)-1:0] push_data,
    input  logic                                  full
);
    import wvl_pkg::*;

    localparam int POS_W = pos_width(MAX_WINDOW_LENGTH);
    localparam int SUM_W = sum_width(MAX_WINDOW_LENGTH);
    localparam int SQ_W  = sq_width(MAX_WINDOW_LENGTH);

    typedef struct packed {
        logic                    close;
        logic                    last;
        logic [POS_W-1:0]        len;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } entry_t;

    logic [CFG_W-1:0]          len_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [POS_W-1:0]          pos_reg;

    logic [POS_W-1:0]          w_eff;
    logic                      accept;
    logic signed [SUM_W-1:0]   x_ext;
    logic signed [2*SAMPLE_W-1:0] x_sq;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SQ_W-1:0]           sq_next;
    logic [POS_W-1:0]          pos_next;
    logic                      close;
    entry_t                    ent;

    always_comb
    begin
        if (len_reg == '0)
        begin
            w_eff = POS_W'(1);
        end
        else if (len_reg > CFG_W'(MAX_WINDOW_LENGTH))
        begin
            w_eff = POS_W'(MAX_WINDOW_LENGTH);
        end
        else
        begin
            w_eff = len_reg[POS_W-1:0];
        end
    end

    assign samples.ready = !full;
    assign accept        = samples.valid && !full;

    assign x_ext    = SUM_W'(samples.sample);
    assign x_sq     = samples.sample * samples.sample;
    assign sum_next = sum_reg + x_ext;
    assign sq_next  = sq_reg + SQ_W'($unsigned(x_sq));
    assign pos_next = pos_reg + 1'b1;
    assign close    = (pos_next >= w_eff);

    assign ent.close = close;
    assign ent.last  = samples.last;
    assign ent.len   = w_eff;
    assign ent.sum   = sum_next;
    assign ent.sq    = sq_next;

    assign push      = accept && (close || samples.last);
    assign push_data = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= RESET_WINDOW_LENGTH;
            sum_reg <= '0;
            sq_reg  <= '0;
            pos_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                len_reg <= cfg_data;
            end
            if (accept)
            begin
                if (close || samples.last)
                begin
                    sum_reg <= '0;
                    sq_reg  <= '0;
                    pos_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    sq_reg  <= sq_next;
                    pos_reg <= pos_next;
                end
            end
        end
    end

endmodule

// ===== sv/wvl_back.sv =====
// ----------------------------------------------------------------------------
// wvl_back
// Folds closed windows into the totals and, at the end of a series, forms
// the variance of variances with a shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
`include "window_variance_lumpiness_assert.svh"

module wvl_back #(
    parameter int MAX_WINDOWS       = wvl_pkg::DEF_MAX_WINDOWS,
    parameter int MAX_WINDOW_LENGTH = wvl_pkg::DEF_MAX_WINDOW_LENGTH,
    parameter int FRACTION_BITS     = wvl_pkg::DEF_FRACTION_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  empty,
    output logic                                  pop,
    input  logic [wvl_pkg::entry_width(MAX_WINDOW_LENGTH)-1:0] pop_data,
    wvl_result_if.source                          results
);
    import wvl_pkg::*;

    localparam int POS_W     = pos_width(MAX_WINDOW_LENGTH);
    localparam int SUM_W     = sum_width(MAX_WINDOW_LENGTH);
    localparam int SQ_W      = sq_width(MAX_WINDOW_LENGTH);
    localparam int U_W       = u_width(MAX_WINDOW_LENGTH);
    localparam int UU_W      = 2 * U_W - 2;
    localparam int CNT_W     = $clog2(MAX_WINDOWS + 1);
    localparam int T_W       = U_W + $clog2(MAX_WINDOWS);
    localparam int Q_W       = UU_W + $clog2(MAX_WINDOWS);
    localparam int KK_W      = 2 * CNT_W;
    localparam int WW_W      = 2 * POS_W;
    localparam int W4_W      = 4 * POS_W;
    localparam int D_W       = KK_W + W4_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef struct packed {
        logic                    close;
        logic                    last;
        logic [POS_W-1:0]        len;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN_MUL,
        ST_WIN_U,
        ST_WIN_SQ,
        ST_WIN_ACC,
        ST_CHECK,
        ST_FIN_MUL,
        ST_FIN_USE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_TT00,
        STEP_TT01,
        STEP_TT11,
        STEP_KQ0,
        STEP_KQ1,
        STEP_KK,
        STEP_WW,
        STEP_W4,
        STEP_D
    } step_t;

    state_t                     state_reg;
    step_t                      step_reg;
    entry_t                     ent_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [T_W-1:0]      t_reg;
    logic [Q_W-1:0]             q_reg;
    logic                       overflow_seen_reg;

    logic [POS_W+SQ_W-1:0]      ws_reg;
    logic signed [2*SUM_W-1:0]  ss_reg;
    logic signed [U_W-1:0]      u_reg;
    logic [UU_W-1:0]            uu_reg;

    logic [2*MUL_W-1:0]         prod_reg;
    logic [NUM_W-1:0]           n_reg;
    logic [KK_W-1:0]            kk_reg;
    logic [WW_W-1:0]            ww_reg;
    logic [W4_W-1:0]            w4_reg;
    logic [D_W-1:0]             d_reg;
    logic [D_W-1:0]             rem_reg;
    logic [LUMP_W-1:0]          quot_reg;
    logic                       sat_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic                       na_reg;

    logic                       out_valid_reg;
    logic [LUMP_W-1:0]          out_lump_reg;
    logic                       out_na_reg;
    logic                       out_ovf_reg;

    entry_t                     pop_ent;
    logic [POS_W+SQ_W-1:0]      ws_next;
    logic signed [2*SUM_W-1:0]  ss_next;
    logic signed [U_W-1:0]      u_next;
    logic signed [2*U_W-1:0]    uu_full;
    logic [2*MUL_W-1:0]         t64;
    logic [2*MUL_W-1:0]         q64;
    logic [MUL_W-1:0]           mul_a;
    logic [MUL_W-1:0]           mul_b;
    logic [2*MUL_W-1:0]         mul_p;
    logic [D_W:0]               r_shift;
    logic [D_W:0]               r_sub;
    logic                       r_ge;
    logic [D_W-1:0]             rem_next;
    logic [LUMP_W-1:0]          res_value;
    logic                       out_free;

    assign pop_ent = entry_t'(pop_data);
    assign pop     = (state_reg == ST_IDLE) && !empty;

    assign ws_next = ent_reg.len * ent_reg.sq;
    assign ss_next = $signed(ent_reg.sum) * $signed(ent_reg.sum);
    assign u_next  = U_W'($signed({1'b0, ws_reg})) - U_W'(ss_reg);
    assign uu_full = u_reg * u_reg;

    assign t64 = (2*MUL_W)'(t_reg);
    assign q64 = (2*MUL_W)'(q_reg);

    always_comb
    begin
        case (step_reg)
            STEP_TT00:
            begin
                mul_a = t64[MUL_W-1:0];
                mul_b = t64[MUL_W-1:0];
            end
            STEP_TT01:
            begin
                mul_a = t64[MUL_W-1:0];
                mul_b = t64[2*MUL_W-1:MUL_W];
            end
            STEP_TT11:
            begin
                mul_a = t64[2*MUL_W-1:MUL_W];
                mul_b = t64[2*MUL_W-1:MUL_W];
            end
            STEP_KQ0:
            begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = q64[MUL_W-1:0];
            end
            STEP_KQ1:
            begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = q64[2*MUL_W-1:MUL_W];
            end
            STEP_KK:
            begin
                mul_a = MUL_W'(cnt_reg);
                mul_b = MUL_W'(cnt_reg);
            end
            STEP_WW:
            begin
                mul_a = MUL_W'(ent_reg.len);
                mul_b = MUL_W'(ent_reg.len);
            end
            STEP_W4:
            begin
                mul_a = MUL_W'(ww_reg);
                mul_b = MUL_W'(ww_reg);
            end
            STEP_D:
            begin
                mul_a = MUL_W'(kk_reg);
                mul_b = MUL_W'(w4_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign r_shift  = {rem_reg, n_reg[NUM_W-1]};
    assign r_ge     = (r_shift >= {1'b0, d_reg});
    assign r_sub    = r_shift - {1'b0, d_reg};
    assign rem_next = r_ge ? r_sub[D_W-1:0] : r_shift[D_W-1:0];

    assign res_value = na_reg ? '0 : (sat_reg ? '1 : quot_reg);
    assign out_free  = !out_valid_reg || results.ready;

    assign results.valid           = out_valid_reg;
    assign results.lumpiness       = out_lump_reg;
    assign results.not_available   = out_na_reg;
    assign results.window_overflow = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_reg          <= STEP_TT00;
            cnt_reg           <= '0;
            t_reg             <= '0;
            q_reg             <= '0;
            overflow_seen_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        ent_reg <= pop_ent;
                        if (pop_ent.close && (cnt_reg < CNT_W'(MAX_WINDOWS)))
                        begin
                            state_reg <= ST_WIN_MUL;
                        end
                        else
                        begin
                            if (pop_ent.close)
                            begin
                                overflow_seen_reg <= 1'b1;
                            end
                            state_reg <= pop_ent.last ? ST_CHECK : ST_IDLE;
                        end
                    end
                end
                ST_WIN_MUL:
                begin
                    ws_reg    <= ws_next;
                    ss_reg    <= ss_next;
                    state_reg <= ST_WIN_U;
                end
                ST_WIN_U:
                begin
                    u_reg     <= u_next;
                    state_reg <= ST_WIN_SQ;
                end
                ST_WIN_SQ:
                begin
                    uu_reg    <= UU_W'($unsigned(uu_full));
                    t_reg     <= t_reg + T_W'(u_reg);
                    state_reg <= ST_WIN_ACC;
                end
                ST_WIN_ACC:
                begin
                    q_reg     <= q_reg + Q_W'(uu_reg);
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= ent_reg.last ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK:
                begin
                    if (cnt_reg < CNT_W'(MIN_WINDOWS))
                    begin
                        na_reg    <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        na_reg    <= 1'b0;
                        n_reg     <= '0;
                        step_reg  <= STEP_TT00;
                        state_reg <= ST_FIN_MUL;
                    end
                end
                ST_FIN_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN_USE;
                end
                ST_FIN_USE:
                begin
                    state_reg <= ST_FIN_MUL;
                    case (step_reg)
                        STEP_TT00:
                        begin
                            n_reg    <= n_reg - NUM_W'(prod_reg);
                            step_reg <= STEP_TT01;
                        end
                        STEP_TT01:
                        begin
                            // cross term counted twice
                            n_reg    <= n_reg - (NUM_W'(prod_reg) << (MUL_W + 1));
                            step_reg <= STEP_TT11;
                        end
                        STEP_TT11:
                        begin
                            n_reg    <= n_reg - (NUM_W'(prod_reg) << (2 * MUL_W));
                            step_reg <= STEP_KQ0;
                        end
                        STEP_KQ0:
                        begin
                            n_reg    <= n_reg + NUM_W'(prod_reg);
                            step_reg <= STEP_KQ1;
                        end
                        STEP_KQ1:
                        begin
                            n_reg    <= n_reg + (NUM_W'(prod_reg) << MUL_W);
                            step_reg <= STEP_KK;
                        end
                        STEP_KK:
                        begin
                            kk_reg   <= prod_reg[KK_W-1:0];
                            step_reg <= STEP_WW;
                        end
                        STEP_WW:
                        begin
                            ww_reg   <= prod_reg[WW_W-1:0];
                            step_reg <= STEP_W4;
                        end
                        STEP_W4:
                        begin
                            w4_reg   <= prod_reg[W4_W-1:0];
                            step_reg <= STEP_D;
                        end
                        STEP_D:
                        begin
                            d_reg       <= prod_reg[D_W-1:0];
                            n_reg       <= n_reg << FRACTION_BITS;
                            rem_reg     <= '0;
                            quot_reg    <= '0;
                            sat_reg     <= 1'b0;
                            div_cnt_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                        default:
                        begin
                            step_reg <= STEP_TT00;
                        end
                    endcase
                end
                ST_DIV:
                begin
                    n_reg       <= n_reg << 1;
                    rem_reg     <= rem_next;
                    quot_reg    <= {quot_reg[LUMP_W-2:0], r_ge};
                    sat_reg     <= sat_reg | quot_reg[LUMP_W-1];
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_lump_reg      <= res_value;
                        out_na_reg        <= na_reg;
                        out_ovf_reg       <= overflow_seen_reg;
                        cnt_reg           <= '0;
                        t_reg             <= '0;
                        q_reg             <= '0;
                        overflow_seen_reg <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `WVL_ASSERT_IMPL(a_div_nonzero, state_reg == ST_DIV, d_reg != '0)
    `WVL_ASSERT_IMPL(a_cnt_bound, state_reg != ST_WIN_ACC, cnt_reg <= CNT_W'(MAX_WINDOWS))
    `WVL_ASSERT_IMPL(a_na_zero, results.valid && results.not_available, results.lumpiness == '0)
    `WVL_ASSERT_NEXT(a_clear_after_out, (state_reg == ST_OUT) && out_free, (cnt_reg == '0) && (q_reg == '0) && (t_reg == '0) && (state_reg == ST_IDLE))

endmodule

// ===== sv/window_variance_lumpiness.sv =====
// ----------------------------------------------------------------------------
// window_variance_lumpiness
// Variance of non-overlapping window variances over a flagged sample series.
// ----------------------------------------------------------------------------
// Samples enter on "samples" (valid/ready); one transaction per cycle while
// the window queue has room. The final sample of a series carries last = 1.
// The back end pops each closed window in IDLE and folds it into the totals
// through WIN_MUL, WIN_U, WIN_SQ and WIN_ACC before it takes the next one.
// After the last sample, the result transaction appears on "results" once
// the back end has folded any final window, checked the window count, formed
// nine products through the shared 32x32 multiplier, run the bit-serial
// divide and loaded the output register. With fewer than two windows the
// products and the divide are skipped.
// window_length is written through cfg_write/cfg_data; the user must write
// it only while idle, as the block itself does not enforce this.
// Reset clears the sums, counts and totals and sets the window length to 10.
// A stalled receiver holds the result in the output register; the front end
// keeps taking samples until the 4-entry queue fills.
// ----------------------------------------------------------------------------
module window_variance_lumpiness #(
    parameter int MAX_WINDOWS       = wvl_pkg::DEF_MAX_WINDOWS,
    parameter int MAX_WINDOW_LENGTH = wvl_pkg::DEF_MAX_WINDOW_LENGTH,
    parameter int FRACTION_BITS     = wvl_pkg::DEF_FRACTION_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [wvl_pkg::CFG_W-1:0] cfg_data,
    wvl_sample_if.sink                samples,
    wvl_result_if.source              results
);
    import wvl_pkg::*;

    localparam int ENTRY_W = entry_width(MAX_WINDOW_LENGTH);

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               full;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;
    logic               empty;

    wvl_front #(
        .MAX_WINDOW_LENGTH (MAX_WINDOW_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    wvl_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    wvl_back #(
        .MAX_WINDOWS       (MAX_WINDOWS),
        .MAX_WINDOW_LENGTH (MAX_WINDOW_LENGTH),
        .FRACTION_BITS     (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop      (pop),
        .pop_data (pop_data),
        .results  (results)
    );

endmodule
